// ===== rtl/core/sfe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfe_pkg
// Shared types, byte codes and checksum helper for the stuffed frame encoder.
// ----------------------------------------------------------------------------
package sfe_pkg;

  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE  = 8'h7D;
  localparam logic [7:0] ESC_XOR   = 8'h20;  // 7e -> 5e, 7d -> 5d

  localparam logic FUNC_BEGIN   = 1'b0;
  localparam logic FUNC_PAYLOAD = 1'b1;

  typedef struct packed {
    logic        func;
    logic [7:0]  data_byte;
    logic [15:0] msg_length;
    logic [15:0] msg_id;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_end;
    logic       error;
  } out_item_t;

  // one classified item, waiting for the byte sequencer
  typedef struct packed {
    logic            is_err;
    logic            is_begin;
    logic            has_cks;
    logic [4:0][7:0] slot;     // unstuffed bytes in send order
  } job_t;

  // 8-bit end-around-carry add
  function automatic logic [7:0] eac_add(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[7:0] + {7'd0, s[8]};
  endfunction

endpackage

// ===== rtl/core/stuffed_frame_encoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stuffed_frame_encoder_core
// Telemetry framer: start marker, stuffed header, payload and checksum bytes.
// ----------------------------------------------------------------------------
//  channel | direction | beat        | handshake
//  in      | input     | in_item_t   | in_valid / in_ready
//  out     | output    | out_item_t  | out_valid / out_ready
//
//  the output runs at one byte per cycle while a job is queued and out_ready is
//  high, set by the sequencer and its output register; a payload beat gives
//  1 to 4 bytes (escape, byte, escape, checksum), a begin beat 5 to 11 and an
//  error beat 1; the front takes a new beat in the same cycle it arrives while
//  the two-entry job queue has room, so input and output stall independently
//  synchronous active-high reset clears the message state, queue and output
// ----------------------------------------------------------------------------
module stuffed_frame_encoder_core import sfe_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  // front to queue
  logic push;
  job_t push_job;
  logic q_full;

  // queue to sequencer
  logic pop;
  logic head_valid;
  job_t head_job;

  // classification and per-message sum tracking
  sfe_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .push     (push),
    .push_job (push_job),
    .q_full   (q_full)
  );

  // decouples intake from byte output
  sfe_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // escape insertion and output register
  sfe_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  // checksum end always closes the run of the beat that caused it
  a_frame_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.frame_end |-> out_data.run_last)
    else $error("frame end without run last");

  // an error beat is a lone zero byte
  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.error |->
      out_data.out_byte == 8'd0 && out_data.run_last && !out_data.frame_end)
    else $error("malformed error beat");

  // nothing leaves straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

// ===== rtl/core/sfe_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfe_front
// Takes input beats, tracks the open message and its sum, and builds jobs.
// ----------------------------------------------------------------------------
module sfe_front import sfe_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     push,
  output job_t     push_job,
  input  logic     q_full
);

  logic [7:0]  running_sum, running_sum_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic        message_open, message_open_next;

  logic [7:0]  hdr_sum;
  logic [7:0]  pay_sum;
  logic [15:0] left_dec;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  always_comb begin
    hdr_sum = eac_add(eac_add(eac_add(in_data.msg_length[7:0], in_data.msg_length[15:8]),
                              in_data.msg_id[7:0]), in_data.msg_id[15:8]);
    pay_sum  = eac_add(running_sum, in_data.data_byte);
    left_dec = bytes_left - 16'd1;

    push_job          = '0;
    running_sum_next  = running_sum;
    bytes_left_next   = bytes_left;
    message_open_next = message_open;

    unique case (in_data.func)
      FUNC_BEGIN: begin
        push_job.is_begin = 1'b1;
        push_job.slot[0]  = in_data.msg_length[7:0];
        push_job.slot[1]  = in_data.msg_length[15:8];
        push_job.slot[2]  = in_data.msg_id[7:0];
        push_job.slot[3]  = in_data.msg_id[15:8];
        push_job.slot[4]  = ~hdr_sum;
        push_job.has_cks  = (in_data.msg_length == 16'd0);
        running_sum_next  = hdr_sum;
        bytes_left_next   = in_data.msg_length;
        message_open_next = (in_data.msg_length != 16'd0);
      end
      FUNC_PAYLOAD: begin
        if (!message_open) begin
          push_job.is_err = 1'b1;
        end else begin
          push_job.slot[0]  = in_data.data_byte;
          push_job.slot[1]  = ~pay_sum;
          push_job.has_cks  = (left_dec == 16'd0);
          running_sum_next  = pay_sum;
          bytes_left_next   = left_dec;
          message_open_next = (left_dec != 16'd0);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum  <= '0;
      bytes_left   <= '0;
      message_open <= 1'b0;
    end else if (push) begin
      running_sum  <= running_sum_next;
      bytes_left   <= bytes_left_next;
      message_open <= message_open_next;
    end
  end

endmodule

// ===== rtl/core/sfe_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfe_queue
// Two-entry job queue between the front and the byte sequencer.
// ----------------------------------------------------------------------------
module sfe_queue import sfe_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output job_t head_job
);

  job_t       entry [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_job   = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== rtl/core/sfe_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfe_back
// Byte sequencer: walks the head job, inserts escapes, drives the output beat.
// ----------------------------------------------------------------------------
module sfe_back import sfe_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      head_valid,
  input  job_t      head_job,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic       flag_sent;
  logic [2:0] idx;
  logic       esc;

  logic [7:0] cur;
  logic [2:0] last_idx;
  logic       special;
  logic       at_last;
  logic       fin;
  logic       step;
  out_item_t  res;

  always_comb begin
    cur      = head_job.slot[idx];
    special  = (cur == FLAG_BYTE) || (cur == ESC_BYTE);
    last_idx = head_job.is_begin ? (head_job.has_cks ? 3'd4 : 3'd3)
                                 : (head_job.has_cks ? 3'd1 : 3'd0);
    at_last  = (idx == last_idx);
    res      = '0;
    fin      = 1'b0;
    priority if (head_job.is_err) begin
      res.error = 1'b1;
      fin       = 1'b1;
    end else if (head_job.is_begin && !flag_sent) begin
      res.out_byte = FLAG_BYTE;
    end else if (esc) begin
      res.out_byte = cur ^ ESC_XOR;
      fin          = at_last;
    end else if (special) begin
      res.out_byte = ESC_BYTE;
    end else begin
      res.out_byte = cur;
      fin          = at_last;
    end
    res.run_last  = fin;
    res.frame_end = fin && head_job.has_cks && !head_job.is_err;
  end

  assign step = head_valid && (!out_valid || out_ready);
  assign pop  = step && fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      flag_sent <= 1'b0;
      idx       <= '0;
      esc       <= 1'b0;
    end else if (step) begin
      priority if (fin) begin
        flag_sent <= 1'b0;
        idx       <= '0;
        esc       <= 1'b0;
      end else if (head_job.is_begin && !flag_sent) begin
        flag_sent <= 1'b1;
      end else if (esc) begin
        esc <= 1'b0;
        idx <= idx + 3'd1;
      end else if (special) begin
        esc <= 1'b1;
      end else begin
        idx <= idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data <= res;
    end
  end

endmodule
